[design/rswp_pkg.sv]
`timescale 1ns / 1ps
package rswp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;

    // register indexes
    localparam logic [2:0] REG_MOUNT_X = 3'd0;
    localparam logic [2:0] REG_MOUNT_Y = 3'd1;
    localparam logic [2:0] REG_MOUNT_A = 3'd2;
    localparam logic [2:0] REG_EAST    = 3'd3;
    localparam logic [2:0] REG_WEST    = 3'd4;
    localparam logic [2:0] REG_NORTH   = 3'd5;
    localparam logic [2:0] REG_SOUTH   = 3'd6;

    // polynomial coefficients of the quarter-wave sine
    localparam logic [15:0] SIN_C0 = 16'd2320;
    localparam logic [15:0] SIN_C1 = 16'd21024;
    localparam logic [15:0] SIN_C2 = 16'd51472;

endpackage

[design/rswp_qsine.sv]
`timescale 1ns / 1ps
// quarter-wave sine, four register stages, one multiply per stage
module rswp_qsine (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_z,
    output logic [16:0] o_s
);
    logic [16:0] r_z1, r_z2a, r_z3;
    logic [15:0] r_zz, r_zz3;
    logic [15:0] r_t2;
    logic [16:0] r_t3;
    logic [16:0] r_s;
    logic [33:0] n_zz;
    logic [31:0] n_p2;
    logic [32:0] n_p3;
    logic [33:0] n_p4;
    logic [15:0] w_q2;
    logic [16:0] w_q3;
    logic [18:0] w_q4;

    assign n_zz = i_z * i_z;
    assign n_p2 = r_zz * rswp_pkg::SIN_C0;
    assign w_q2 = 16'(n_p2 >> 15);
    assign n_p3 = r_t2 * {1'b0, r_zz3};
    assign w_q3 = 17'(n_p3 >> 15);
    assign n_p4 = r_z3 * r_t3;
    assign w_q4 = 19'(n_p4 >> 15);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1  <= i_z;
            r_zz  <= 16'(n_zz >> 15);
            r_z2a <= r_z1;
            r_zz3 <= r_zz;
            r_t2  <= rswp_pkg::SIN_C1 - w_q2;
            r_z3  <= r_z2a;
            r_t3  <= {1'b0, rswp_pkg::SIN_C2} - w_q3;
            r_s   <= (w_q4 > 19'd32768) ? 17'd32768 : w_q4[16:0];
        end
    end
    assign o_s = r_s;
endmodule

[design/range_sensor_world_position_core.sv]
`timescale 1ns / 1ps
// channel    | dir | handshake        | payload
// s_axis     | in  | tvalid/tready    | tdata: vehicle_x, vehicle_y, heading, range
// m_axis     | out | tvalid/tready    | tdata: sensor x/y, object x/y; tuser: valid, inside
// cfg        | in  | valid/ready      | index, data
// one beat accepted per cycle while the output is not stalled; the pipeline is set by the sine polynomial
// (four multiplies) and the rotate, accumulate and compare stages after it
// reset is synchronous; it clears the valid bits and loads the register defaults
// the whole pipeline advances only when the last stage is empty or taken, so a
// stall holds every beat in place
module range_sensor_world_position_core #(
    parameter int COORD_BITS = rswp_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = rswp_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // vehicle_x, vehicle_y, vehicle_heading, range_reading (low bits up)
    input  logic [((3*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // sensor_world_x, sensor_world_y, object_world_x, object_world_y
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // reading_valid, inside_area
    output logic [1:0]            m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    localparam int CB = COORD_BITS;
    localparam int AB = ANGLE_BITS;
    localparam int NS = 9;
    localparam int IW = ((3*CB+AB+7)/8)*8;
    localparam int OW = ((4*CB+7)/8)*8;
    localparam int PW = CB + 19;  // product width
    localparam int AW = CB + 21;  // accumulation width

    // configuration registers
    logic signed [CB-1:0] r_ox, r_oy, r_east, r_west, r_north, r_south;
    logic [AB-1:0] r_mang;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0; r_oy <= '0; r_mang <= '0;
            r_east <= {1'b0, {(CB-1){1'b1}}}; r_west <= {1'b1, {(CB-1){1'b0}}};
            r_north <= {1'b0, {(CB-1){1'b1}}}; r_south <= {1'b1, {(CB-1){1'b0}}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rswp_pkg::REG_MOUNT_X: r_ox <= i_cfg_data[CB-1:0];
                rswp_pkg::REG_MOUNT_Y: r_oy <= i_cfg_data[CB-1:0];
                rswp_pkg::REG_MOUNT_A: r_mang <= i_cfg_data[AB-1:0];
                rswp_pkg::REG_EAST:    r_east <= i_cfg_data[CB-1:0];
                rswp_pkg::REG_WEST:    r_west <= i_cfg_data[CB-1:0];
                rswp_pkg::REG_NORTH:   r_north <= i_cfg_data[CB-1:0];
                rswp_pkg::REG_SOUTH:   r_south <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: single enable for all stages
    logic [NS-1:0] r_vld;
    logic w_en;
    assign w_en = !r_vld[NS-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[NS-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[NS-2:0], s_axis_tvalid};
    end

    // input fields
    logic signed [CB-1:0] w_vx, w_vy, w_rng;
    logic [AB-1:0] w_hd, w_ha;
    assign w_vx  = s_axis_tdata[CB-1:0];
    assign w_vy  = s_axis_tdata[2*CB-1:CB];
    assign w_hd  = s_axis_tdata[2*CB+AB-1:2*CB];
    assign w_rng = s_axis_tdata[3*CB+AB-1:2*CB+AB];
    assign w_ha  = w_hd + r_mang;

    // stage 0: quadrant and z for both angles
    function automatic logic [15:0] f_z(input logic [AB-1:0] a);
        logic [AB-3:0] f;
        f = a[AB-3:0];
        if (AB <= 17) f_z = 16'({1'b0, f} << (17 - AB));
        else f_z = 16'(f >> (AB - 17));
    endfunction

    logic [15:0] r_zh, r_za;
    logic [16:0] r_zhc, r_zac;
    logic [1:0] r_q [NS];
    logic [1:0] r_qa [NS];
    logic signed [CB-1:0] r_vx [NS];
    logic signed [CB-1:0] r_vy [NS];
    logic signed [CB-1:0] r_rg [NS];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zh  <= f_z(w_hd);
            r_zhc <= 17'd32768 - {1'b0, f_z(w_hd)};
            r_za  <= f_z(w_ha);
            r_zac <= 17'd32768 - {1'b0, f_z(w_ha)};
            r_q[0] <= w_hd[AB-1:AB-2];
            r_qa[0] <= w_ha[AB-1:AB-2];
            r_vx[0] <= w_vx; r_vy[0] <= w_vy; r_rg[0] <= w_rng;
            for (int i = 1; i < NS; i++) begin
                r_q[i] <= r_q[i-1]; r_qa[i] <= r_qa[i-1];
                r_vx[i] <= r_vx[i-1]; r_vy[i] <= r_vy[i-1]; r_rg[i] <= r_rg[i-1];
            end
        end
    end

    // stages 1..4: sine polynomial; the complement side carries 17 bits so
    // that z = 0 gives the full-scale value 32768
    logic [16:0] w_a, w_b, w_aa, w_ba;
    rswp_qsine u_sa  (.i_clk, .i_en(w_en), .i_z({1'b0, r_zh}), .o_s(w_a));
    rswp_qsine u_sb  (.i_clk, .i_en(w_en), .i_z(r_zhc),        .o_s(w_b));
    rswp_qsine u_saa (.i_clk, .i_en(w_en), .i_z({1'b0, r_za}), .o_s(w_aa));
    rswp_qsine u_sba (.i_clk, .i_en(w_en), .i_z(r_zac),        .o_s(w_ba));

    // stage 5: quadrant fold (results at index 4)
    function automatic void f_fold(input logic [1:0] q, input logic [16:0] a,
                                   input logic [16:0] b, output logic signed [17:0] s,
                                   output logic signed [17:0] c);
        logic signed [17:0] sa, sb;
        sa = {1'b0, a};
        sb = {1'b0, b};
        case (q)
            2'd0: begin s = sa; c = sb; end
            2'd1: begin s = sb; c = -sa; end
            2'd2: begin s = -sa; c = -sb; end
            default: begin s = -sb; c = sa; end
        endcase
    endfunction

    logic signed [17:0] n_sh, n_ch, n_ss, n_cs, r_sh, r_ch, r_ss, r_cs;
    always_comb begin
        f_fold(r_q[4], w_a, w_b, n_sh, n_ch);
        f_fold(r_qa[4], w_aa, w_ba, n_ss, n_cs);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sh <= n_sh; r_ch <= n_ch; r_ss <= n_ss; r_cs <= n_cs;
        end
    end

    // stage 6: products (index 5 data)
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0 <= PW'(r_ox * r_ch);
            r_p1 <= PW'(r_oy * r_sh);
            r_p2 <= PW'(r_ox * r_sh);
            r_p3 <= PW'(r_oy * r_ch);
            r_p4 <= PW'(r_rg[5] * r_cs);
            r_p5 <= PW'(r_rg[5] * r_ss);
        end
    end

    // stage 7: exact sums, rounding and saturation (index 6 data)
    function automatic logic signed [CB-1:0] f_out(input logic signed [CB-1:0] v,
                                                   input logic signed [AW-1:0] p);
        logic [AW-1:0] m;
        logic signed [AW-1:0] r, t;
        m = p[AW-1] ? AW'(-p) : AW'(p);
        m = (m + AW'(16384)) >> 15;
        r = p[AW-1] ? -$signed(m) : $signed(m);
        t = r + AW'(v);
        if (t > $signed(AW'({1'b0, {(CB-1){1'b1}}}))) f_out = {1'b0, {(CB-1){1'b1}}};
        else if (t < -$signed(AW'({1'b0, {(CB-1){1'b1}}})) - 1)
            f_out = {1'b1, {(CB-1){1'b0}}};
        else f_out = t[CB-1:0];
    endfunction

    logic signed [AW-1:0] w_rx, w_ry;
    logic w_ok6;
    logic signed [CB-1:0] r_sx, r_sy, r_bx, r_by;
    logic r_ok7;
    assign w_rx = AW'(r_p0) - AW'(r_p1);
    assign w_ry = AW'(r_p2) + AW'(r_p3);
    assign w_ok6 = !r_rg[6][CB-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx <= f_out(r_vx[6], w_rx);
            r_sy <= f_out(r_vy[6], w_ry);
            r_bx <= w_ok6 ? f_out(r_vx[6], w_rx + AW'(r_p4)) : '0;
            r_by <= w_ok6 ? f_out(r_vy[6], w_ry + AW'(r_p5)) : '0;
            r_ok7 <= w_ok6;
        end
    end

    // stage 8: rectangle test
    logic signed [CB-1:0] r_osx, r_osy, r_obx, r_oby;
    logic r_ook, r_oin;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_osx <= r_sx; r_osy <= r_sy; r_obx <= r_bx; r_oby <= r_by;
            r_ook <= r_ok7;
            r_oin <= r_ok7 && r_bx <= r_east && r_bx >= r_west &&
                     r_by <= r_north && r_by >= r_south;
        end
    end

    assign m_axis_tdata = OW'({r_oby, r_obx, r_osy, r_osx});
    assign m_axis_tuser = {r_oin, r_ook};

    logic w_unused;
    assign w_unused = ^s_axis_tdata[IW-1:3*CB+AB-1] ^ ^i_cfg_data ^ ^r_q[NS-1] ^ ^r_qa[NS-1]
                      ^ ^r_vx[NS-1] ^ ^r_vy[NS-1] ^ ^r_rg[NS-1];

    a_inside_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]) else $error("inside without valid");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> r_obx == '0 && r_oby == '0)
        else $error("invalid object not zero");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld)) else $error("pipeline moved in stall");
endmodule

[verif/range_sensor_world_position_core_tb.sv]
`timescale 1ns / 1ps
module range_sensor_world_position_core_tb;

    // index past the last register; the block must ignore writes to it
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // pipeline depth is 9; the settle wait is longer than that
    localparam int SETTLE_CYCLES = 14;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 200;

    // expected world positions for every accepted pose beat
    class world_position_scoreboard;
        logic signed [15:0] mnt_x, mnt_y, east, west, north, south;
        logic [15:0] mnt_ang;
        logic [65:0] pending_results[$];   // {flags, positions}
        int errors;

        function new();
            mnt_x = '0; mnt_y = '0; mnt_ang = '0;
            east = 16'sh7fff; west = 16'sh8000;
            north = 16'sh7fff; south = 16'sh8000;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                rswp_pkg::REG_MOUNT_X: mnt_x = val[15:0];
                rswp_pkg::REG_MOUNT_Y: mnt_y = val[15:0];
                rswp_pkg::REG_MOUNT_A: mnt_ang = val[15:0];
                rswp_pkg::REG_EAST: east = val[15:0];
                rswp_pkg::REG_WEST: west = val[15:0];
                rswp_pkg::REG_NORTH: north = val[15:0];
                rswp_pkg::REG_SOUTH: south = val[15:0];
                default: ;
            endcase
        endfunction

        function longint quarter_sine(longint z);
            longint z2, t;
            z2 = (z * z) >>> 15;
            t = 21024 - ((2320 * z2) >>> 15);
            t = 51472 - ((t * z2) >>> 15);
            t = (z * t) >>> 15;
            return (t > 32768) ? 32768 : t;
        endfunction

        function void sin_cos(logic [15:0] ang, output longint s, output longint c);
            longint z, a, b;
            z = longint'(ang[13:0]) << 1;
            a = quarter_sine(z);
            b = quarter_sine(32768 - z);
            case (ang[15:14])
                2'd0: begin s = a; c = b; end
                2'd1: begin s = b; c = -a; end
                2'd2: begin s = -a; c = -b; end
                default: begin s = -b; c = a; end
            endcase
        endfunction

        // divide by 2^15, ties away from zero
        function longint round_q15(longint v);
            if (v < 0) return -((-v + 16384) >>> 15);
            return (v + 16384) >>> 15;
        endfunction

        function logic [15:0] clamp(longint v);
            if (v > 32767) return 16'h7fff;
            if (v < -32768) return 16'h8000;
            return v[15:0];
        endfunction

        function void note_beat(logic [63:0] d);
            longint vx, vy, rng, ox, oy, sh, ch, ss, cs, rx, ry, objx, objy;
            logic [15:0] sx, sy;
            logic valid, in_area;
            vx = longint'($signed(d[15:0]));
            vy = longint'($signed(d[31:16]));
            rng = longint'($signed(d[63:48]));
            ox = longint'(mnt_x);
            oy = longint'(mnt_y);
            sin_cos(d[47:32], sh, ch);
            rx = ox * ch - oy * sh;
            ry = ox * sh + oy * ch;
            sx = clamp(vx + round_q15(rx));
            sy = clamp(vy + round_q15(ry));
            valid = (rng >= 0);
            in_area = 1'b0;
            objx = 0;
            objy = 0;
            if (valid) begin
                // angle sum wraps at 16 bits
                sin_cos(d[47:32] + mnt_ang, ss, cs);
                objx = longint'($signed(clamp(vx + round_q15(rx + rng * cs))));
                objy = longint'($signed(clamp(vy + round_q15(ry + rng * ss))));
                in_area = objx <= east && objx >= west && objy <= north && objy >= south;
            end
            pending_results.push_back({in_area, valid, objy[15:0], objx[15:0], sy, sx});
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        endtask

        task check_beat(logic [63:0] d, logic [1:0] u);
            logic [65:0] want;
            string names[4] = '{"sensor_world_x", "sensor_world_y",
                                "object_world_x", "object_world_y"};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", d[15:0], 16'h0);
                return;
            end
            want = pending_results.pop_front();
            for (int k = 0; k < 4; k++)
                if (d[16*k +: 16] !== want[16*k +: 16])
                    report_mismatch(names[k], d[16*k +: 16], want[16*k +: 16]);
            if (u[0] !== want[64])
                report_mismatch("reading_valid", {15'd0, u[0]}, {15'd0, want[64]});
            if (u[1] !== want[65])
                report_mismatch("inside_area", {15'd0, u[1]}, {15'd0, want[65]});
        endtask
    endclass

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic i_cfg_valid, o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    world_position_scoreboard sb;
    int cycle_count = 0;
    int hold_left;      // long receiver hold-off, counted down by the receiver
    bit rx_stalls;      // receiver idles at random when set
    bit tx_gaps;        // sender leaves gaps when set

    range_sensor_world_position_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: sample at the rising edge
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser);

    // result side ready: short stalls mostly, a few long, plus the long hold-off
    initial begin : rx_ready_gen
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task wait_idle();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_cfg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        // bits above the register width must be ignored
        i_cfg_data <= {16'($urandom_range(0, 65535)), val};
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, i_cfg_data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one pose beat; valid stays high into the next beat unless a gap follows
    task send_pose(logic [15:0] vx, logic [15:0] vy, logic [15:0] hd, logic [15:0] rng);
        int gap;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rng, hd, vy, vx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(s_axis_tdata);
    endtask

    task stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // random pose: full range or close to the origin so the rectangle gets hit
    task send_random_pose();
        logic [15:0] vx, vy, rng;
        if ($urandom_range(0, 1) == 0) begin
            vx = 16'($urandom); vy = 16'($urandom); rng = 16'($urandom);
        end else begin
            vx = 16'($urandom_range(0, 4000)) - 16'd2000;
            vy = 16'($urandom_range(0, 4000)) - 16'd2000;
            rng = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3000)) - 16'd1500
                                              : 16'($urandom_range(0, 3000));
        end
        send_pose(vx, vy, 16'($urandom), rng);
    endtask

    function logic [15:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 6000)) - 16'd3000;
        endcase
    endfunction

    task program_phase(int phase);
        logic [15:0] a, b, c, d;
        write_cfg(rswp_pkg::REG_MOUNT_X, pick_coord());
        write_cfg(rswp_pkg::REG_MOUNT_Y, pick_coord());
        write_cfg(rswp_pkg::REG_MOUNT_A, (phase == 1) ? 16'hffff : 16'($urandom));
        a = 16'($urandom_range(0, 4000)) - 16'd2000;
        b = 16'($urandom_range(0, 4000)) - 16'd2000;
        c = 16'($urandom_range(0, 4000)) - 16'd2000;
        d = 16'($urandom_range(0, 4000)) - 16'd2000;
        // every third phase may leave the rectangle empty in one direction
        if (phase % 3 == 2 || $signed(a) >= $signed(b)) begin
            write_cfg(rswp_pkg::REG_EAST, a);
            write_cfg(rswp_pkg::REG_WEST, b);
        end else begin
            write_cfg(rswp_pkg::REG_EAST, b);
            write_cfg(rswp_pkg::REG_WEST, a);
        end
        if ($signed(c) >= $signed(d)) begin
            write_cfg(rswp_pkg::REG_NORTH, c);
            write_cfg(rswp_pkg::REG_SOUTH, d);
        end else begin
            write_cfg(rswp_pkg::REG_NORTH, d);
            write_cfg(rswp_pkg::REG_SOUTH, c);
        end
        write_cfg(REG_UNUSED, 16'($urandom));
    endtask

    initial begin
        sb = new();
        hold_left = 0;
        rx_stalls = 1'b0;
        tx_gaps = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = rswp_pkg::REG_MOUNT_X;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults, extremes of pose, quadrant boundaries
        send_pose(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pose(16'h7fff, 16'h7fff, 16'h4000, 16'h7fff);
        send_pose(16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        send_pose(16'h7fff, 16'h8000, 16'hc000, 16'h7fff);
        send_pose(16'h1234, 16'hedcc, 16'hffff, 16'hffff);   // invalid reading
        send_pose(16'h0000, 16'h0000, 16'h0001, 16'h8000);   // most negative range
        send_pose(16'h8000, 16'h7fff, 16'h2000, 16'h0001);
        send_pose(16'h0100, 16'hff00, 16'h3fff, 16'h0100);
        stop_sending();
        wait_idle();

        // directed with extreme mount so the rotation saturates
        write_cfg(rswp_pkg::REG_MOUNT_X, 16'h8000);
        write_cfg(rswp_pkg::REG_MOUNT_Y, 16'h7fff);
        write_cfg(rswp_pkg::REG_MOUNT_A, 16'hc000);
        write_cfg(rswp_pkg::REG_EAST, 16'h0000);
        write_cfg(rswp_pkg::REG_WEST, 16'h0000);
        write_cfg(rswp_pkg::REG_NORTH, 16'h0000);
        write_cfg(rswp_pkg::REG_SOUTH, 16'h0000);
        send_pose(16'h7fff, 16'h7fff, 16'h0000, 16'h7fff);
        send_pose(16'h8000, 16'h8000, 16'h6000, 16'h7fff);
        send_pose(16'h0000, 16'h0000, 16'ha000, 16'h0000);
        send_pose(16'h0000, 16'h0000, 16'he000, 16'hfffe);
        send_pose(16'h4000, 16'hc000, 16'h5555, 16'h2000);
        stop_sending();
        wait_idle();
        write_cfg(rswp_pkg::REG_MOUNT_X, 16'h0000);
        write_cfg(rswp_pkg::REG_MOUNT_Y, 16'h0000);
        write_cfg(rswp_pkg::REG_MOUNT_A, 16'h0000);
        send_pose(16'h0000, 16'h0000, 16'h0000, 16'h0000);   // lands on the point box
        send_pose(16'h0000, 16'h0001, 16'h0000, 16'h0000);
        stop_sending();
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            program_phase(ph);
            rx_stalls = (ph % 4 != 0);
            tx_gaps = (ph % 4 != 1);
            if (ph == 3) begin
                // back-pressure: receiver holds off while the sender keeps going
                tx_gaps = 1'b0;
                hold_left = 300;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_pose();
            // sender pauses until every result is back
            stop_sending();
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
design/rswp_pkg.sv
design/rswp_qsine.sv
design/range_sensor_world_position_core.sv
verif/range_sensor_world_position_core_tb.sv
